>>> src/assert_macros.svh
// Assertion macros shared by the key table RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset.
`define KT_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define KT_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define KT_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> src/kertr_pkg.sv
// Types and constants for the key edge and typematic repeat unit.
// No dependencies; imported by kertr_ram users and the top level.
package kertr_pkg;

  localparam int KEY_COUNT  = 256;
  localparam int KEY_AW     = $clog2(KEY_COUNT);
  localparam int TIME_BITS  = 32;
  localparam int KEY_CMP_W  = 11;   // wide enough for any key count up to 1024

  localparam int DELAY_W    = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST = 16'd500;
  localparam logic [DELAY_W-1:0] REPEAT_RST      = 16'd100;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT      = 2'd1;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_PRESSED = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  localparam logic [1:0] MODE_LEVEL  = 2'd0;
  localparam logic [1:0] MODE_ONCE   = 2'd1;
  localparam logic [1:0] MODE_REPEAT = 2'd2;

  typedef struct packed {
    logic                 held_now;
    logic                 held_before;
    logic [TIME_BITS-1:0] first_press;
    logic [TIME_BITS-1:0] last_repeat;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

endpackage

>>> src/kertr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kertr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/key_edge_and_typematic_repeat_unit.sv
// Keyboard per-key state table: edge detection and typematic auto-repeat.
// Depends on kertr_pkg, kertr_ram and assert_macros.svh.
//
// Usage: items enter on in_valid/in_ready (operation, key_index, key_level,
// query_mode); each item yields exactly one transaction on out_valid/out_ready
// carrying answer. A tick advances the millisecond count, a sample stores a
// key level, a pressed or released query reads one key's entry, and a pressed
// query in repeat mode restamps its timestamps.
// Configuration writes come on cfg_valid/cfg_ready with cfg_index/cfg_data
// (0: first-press delay, 1: repeat interval, both in ms); cfg_ready is
// always high. Write configuration only while the unit is idle.
// Timing: the table RAM read is issued at the accepting edge; answer and
// out_valid are registered as the item leaves the evaluate stage.
// Throughput: one item per cycle unless out_ready stalls the output; the key
// entry is a read-modify-write on a one-port-read, one-port-write RAM with
// a forwarding register covering back-to-back accesses to the same key.
// Reset: all keys read as released with zero timestamps (per-key valid
// flops), count is zero, registers return to 500 and 100. No clearing
// pass is needed, items are accepted right after reset.
// Stall: when out_ready is low the result is held in the output register;
// one further item may sit in the evaluate stage, then in_ready drops.
module key_edge_and_typematic_repeat_unit
  import kertr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           operation,
  input  logic [7:0]           key_index,
  input  logic                 key_level,
  input  logic [1:0]           query_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 answer,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DELAY_W-1:0]   cfg_data
);

`include "assert_macros.svh"

  logic [DELAY_W-1:0]   first_delay;
  logic [DELAY_W-1:0]   repeat_interval;
  logic [TIME_BITS-1:0] ms_count;
  logic [TIME_BITS-1:0] ms_count_next;

  logic                 s1_valid;
  op_t                  s1_op;
  logic [KEY_AW-1:0]    s1_key;
  logic                 s1_level;
  logic [1:0]           s1_mode;
  logic                 s1_in_range;

  logic                 fwd_hit;
  entry_t               fwd_data;
  logic [KEY_COUNT-1:0] key_valid;

  logic                 in_fire;
  logic                 out_free;
  logic                 advance;
  logic                 in_range;
  logic [KEY_AW-1:0]    in_key;

  logic [ENTRY_BITS-1:0] ram_q;
  entry_t               cur;
  entry_t               wr_entry;
  logic                 wr_req;
  logic                 ram_we;
  logic                 ans_next;

  logic [TIME_BITS-1:0] since_first;
  logic [TIME_BITS-1:0] since_repeat;
  logic                 repeat_due;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign advance   = s1_valid && out_free;
  assign in_ready  = !s1_valid || out_free;
  assign in_fire   = in_valid && in_ready;
  assign in_key    = KEY_AW'(key_index);
  assign in_range  = KEY_CMP_W'(key_index) < KEY_CMP_W'(KEY_COUNT);
  assign ram_we    = advance && wr_req;

  kertr_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(KEY_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_key),
    .wdata(wr_entry),
    .re   (in_fire),
    .raddr(in_key),
    .rdata(ram_q)
  );

  // Entry seen by the evaluate stage: forwarded write, stored data, or reset value.
  always_comb begin
    if (fwd_hit) begin
      cur = fwd_data;
    end else if (key_valid[s1_key]) begin
      cur = entry_t'(ram_q);
    end else begin
      cur = '0;
    end
  end

  assign since_first  = ms_count - cur.first_press;
  assign since_repeat = ms_count - cur.last_repeat;
  assign repeat_due   = (since_first >= TIME_BITS'(first_delay)) &&
                        (since_repeat >= TIME_BITS'(repeat_interval));

  always_comb begin
    ans_next      = 1'b0;
    wr_req        = 1'b0;
    wr_entry      = cur;
    ms_count_next = ms_count;
    case (s1_op)
      OP_TICK: begin
        ms_count_next = ms_count + 1'b1;
      end
      OP_SAMPLE: begin
        if (s1_in_range) begin
          wr_req               = 1'b1;
          wr_entry.held_before = cur.held_now;
          wr_entry.held_now    = s1_level;
        end
      end
      OP_PRESSED: begin
        if (s1_in_range) begin
          case (s1_mode)
            MODE_LEVEL:  ans_next = cur.held_now;
            MODE_ONCE:   ans_next = cur.held_now && !cur.held_before;
            MODE_REPEAT: begin
              if (cur.held_now && !cur.held_before) begin
                ans_next             = 1'b1;
                wr_req               = 1'b1;
                wr_entry.first_press = ms_count;
                wr_entry.last_repeat = ms_count;
              end else if (cur.held_now && repeat_due) begin
                ans_next             = 1'b1;
                wr_req               = 1'b1;
                wr_entry.last_repeat = ms_count;
              end
            end
            default: ans_next = 1'b0;
          endcase
        end
      end
      OP_RELEASE: begin
        if (s1_in_range) begin
          case (s1_mode)
            MODE_LEVEL:  ans_next = !cur.held_now;
            MODE_ONCE:   ans_next = cur.held_before && !cur.held_now;
            MODE_REPEAT: ans_next = cur.held_before && !cur.held_now;
            default:     ans_next = 1'b0;
          endcase
        end
      end
      default: ans_next = 1'b0;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_delay     <= FIRST_DELAY_RST;
      repeat_interval <= REPEAT_RST;
      ms_count        <= '0;
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      fwd_hit         <= 1'b0;
      key_valid       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIRST_DELAY: first_delay     <= cfg_data;
          REG_REPEAT:      repeat_interval <= cfg_data;
          default: ;
        endcase
      end
      if (advance) begin
        ms_count <= ms_count_next;
      end
      if (ram_we) begin
        key_valid[s1_key] <= 1'b1;
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
        fwd_hit  <= ram_we && (in_key == s1_key);
      end else if (advance) begin
        s1_valid <= 1'b0;
        fwd_hit  <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op       <= op_t'(operation);
      s1_key      <= in_key;
      s1_level    <= key_level;
      s1_mode     <= query_mode;
      s1_in_range <= in_range;
    end
    if (ram_we) begin
      fwd_data <= wr_entry;
    end
    if (advance) begin
      answer <= ans_next;
    end
  end

  `KT_ASSERT_IMP(a_we_only_on_advance, ram_we, advance && s1_in_range && s1_op != OP_TICK,
                 "table write without a live in-range item")
  `KT_ASSERT_IMP(a_fwd_needs_item, fwd_hit, s1_valid,
                 "forwarding flag set with empty evaluate stage")
  `KT_ASSERT_NXT(a_tick_counts, advance && s1_op == OP_TICK,
                 ms_count == $past(ms_count) + 1'b1, "tick did not advance count")
  `KT_ASSERT_NXT(a_nonquery_zero, advance && (s1_op == OP_TICK || s1_op == OP_SAMPLE),
                 out_valid && !answer, "tick or sample produced a nonzero answer")

endmodule

>>> verif/tb_key_edge_and_typematic_repeat_unit.sv
// Testbench for key_edge_and_typematic_repeat_unit: directed table, then random
// key press/hold/release traffic checked against an in-bench key table model.
// Depends on kertr_pkg and the unit RTL only.
module tb_key_edge_and_typematic_repeat_unit;
  import kertr_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int NUM_DIRECTED   = 25;
  localparam int NUM_PHASES     = 9;
  localparam int ITEMS_PER_PHASE = 192;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           operation = OP_TICK;
  logic [7:0]           key_index = 8'd0;
  logic                 key_level = 1'b0;
  logic [1:0]           query_mode = MODE_LEVEL;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 answer;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FIRST_DELAY;
  logic [DELAY_W-1:0]   cfg_data = '0;

  key_edge_and_typematic_repeat_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .key_index(key_index),
    .key_level(key_level), .query_mode(query_mode),
    .out_valid(out_valid), .out_ready(out_ready), .answer(answer),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Key table model
  bit                   key_down [KEY_COUNT];
  bit                   key_down_prev [KEY_COUNT];
  logic [TIME_BITS-1:0] press_stamp [KEY_COUNT];
  logic [TIME_BITS-1:0] repeat_stamp [KEY_COUNT];
  logic [TIME_BITS-1:0] ms_count;
  logic [DELAY_W-1:0]   delay_cfg;
  logic [DELAY_W-1:0]   interval_cfg;

  bit pending_answers [$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  typedef struct {
    op_t        op;
    logic [7:0] key;
    logic       lvl;
    logic [1:0] mode;
    bit         fixed;   // expected answer typed in below
    bit         ans;
  } dir_row_t;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_PRESSED, 8'd0,   1'b0, MODE_LEVEL,  1'b1, 1'b0},
    '{OP_RELEASE, 8'd0,   1'b0, MODE_LEVEL,  1'b1, 1'b1},
    '{OP_PRESSED, 8'd0,   1'b0, MODE_ONCE,   1'b1, 1'b0},
    '{OP_RELEASE, 8'd0,   1'b0, MODE_ONCE,   1'b1, 1'b0},
    '{OP_PRESSED, 8'd0,   1'b0, MODE_REPEAT, 1'b1, 1'b0},
    '{OP_RELEASE, 8'd255, 1'b0, MODE_REPEAT, 1'b1, 1'b0},
    '{OP_SAMPLE,  8'd255, 1'b1, MODE_LEVEL,  1'b1, 1'b0},
    '{OP_PRESSED, 8'd255, 1'b0, MODE_LEVEL,  1'b1, 1'b1},
    '{OP_PRESSED, 8'd255, 1'b0, MODE_ONCE,   1'b1, 1'b1},
    '{OP_PRESSED, 8'd255, 1'b0, MODE_UNUSED, 1'b1, 1'b0},
    '{OP_RELEASE, 8'd255, 1'b0, MODE_UNUSED, 1'b1, 1'b0},
    '{OP_PRESSED, 8'd255, 1'b0, MODE_REPEAT, 1'b1, 1'b1},
    '{OP_PRESSED, 8'd255, 1'b0, MODE_REPEAT, 1'b0, 1'b0},
    '{OP_TICK,    8'd0,   1'b0, MODE_LEVEL,  1'b1, 1'b0},
    '{OP_SAMPLE,  8'd255, 1'b1, MODE_LEVEL,  1'b1, 1'b0},
    '{OP_PRESSED, 8'd255, 1'b0, MODE_ONCE,   1'b0, 1'b0},
    '{OP_PRESSED, 8'd255, 1'b0, MODE_REPEAT, 1'b0, 1'b0},
    '{OP_RELEASE, 8'd255, 1'b0, MODE_ONCE,   1'b0, 1'b0},
    '{OP_SAMPLE,  8'd255, 1'b0, MODE_UNUSED, 1'b1, 1'b0},
    '{OP_RELEASE, 8'd255, 1'b0, MODE_ONCE,   1'b0, 1'b0},
    '{OP_RELEASE, 8'd255, 1'b0, MODE_REPEAT, 1'b0, 1'b0},
    '{OP_RELEASE, 8'd255, 1'b0, MODE_LEVEL,  1'b0, 1'b0},
    '{OP_SAMPLE,  8'haa,  1'b1, MODE_ONCE,   1'b1, 1'b0},
    '{OP_PRESSED, 8'haa,  1'b1, MODE_REPEAT, 1'b0, 1'b0},
    '{OP_PRESSED, 8'h55,  1'b1, MODE_ONCE,   1'b0, 1'b0}
  };

  function automatic void reset_key_table();
    for (int k = 0; k < KEY_COUNT; k++) begin
      key_down[k]      = 1'b0;
      key_down_prev[k] = 1'b0;
      press_stamp[k]   = '0;
      repeat_stamp[k]  = '0;
    end
    ms_count     = '0;
    delay_cfg    = FIRST_DELAY_RST;
    interval_cfg = REPEAT_RST;
  endfunction

  // Applies one item to the key table and returns the answer it produces.
  function automatic bit key_table_step(op_t op, logic [7:0] key, logic lvl,
                                        logic [1:0] mode);
    bit now;
    bit prev;
    logic [TIME_BITS-1:0] since_press;
    logic [TIME_BITS-1:0] since_repeat;
    now  = key_down[key];
    prev = key_down_prev[key];
    since_press  = ms_count - press_stamp[key];
    since_repeat = ms_count - repeat_stamp[key];
    case (op)
      OP_TICK: begin
        ms_count = ms_count + 1'b1;
        return 1'b0;
      end
      OP_SAMPLE: begin
        key_down_prev[key] = now;
        key_down[key]      = lvl;
        return 1'b0;
      end
      OP_PRESSED: begin
        case (mode)
          MODE_LEVEL: return now;
          MODE_ONCE:  return now && !prev;
          MODE_REPEAT: begin
            if (!now) return 1'b0;
            if (!prev) begin
              press_stamp[key]  = ms_count;
              repeat_stamp[key] = ms_count;
              return 1'b1;
            end
            if (since_press >= TIME_BITS'(delay_cfg) &&
                since_repeat >= TIME_BITS'(interval_cfg)) begin
              repeat_stamp[key] = ms_count;
              return 1'b1;
            end
            return 1'b0;
          end
          default: return 1'b0;
        endcase
      end
      default: begin
        case (mode)
          MODE_LEVEL:             return !now;
          MODE_ONCE, MODE_REPEAT: return prev && !now;
          default:                return 1'b0;
        endcase
      end
    endcase
  endfunction

  // Offer one item; gaps before it follow send_idle_pct.
  task automatic send_item(op_t op, logic [7:0] key, logic lvl, logic [1:0] mode,
                           bit fixed, bit fixed_ans);
    bit predicted;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    key_index  <= key;
    key_level  <= lvl;
    query_mode <= mode;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = key_table_step(op, key, lvl, mode);
    pending_answers.push_back(fixed ? fixed_ans : predicted);
  endtask

  // Stop offering and wait until every outstanding answer is back.
  task automatic drain_answers();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DELAY_W-1:0] data);
    drain_answers();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FIRST_DELAY: delay_cfg = data;
      REG_REPEAT:      interval_cfg = data;
      default: ;
    endcase
  endtask

  // Mostly press/hold/release traffic on a few keys, with some stray keys.
  task automatic send_random_item(logic [7:0] pool [4]);
    int r;
    logic [7:0] key;
    logic [1:0] mode;
    op_t op;
    r = $urandom_range(0, 99);
    key = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                      : pool[$urandom_range(0, 3)];
    mode = 2'($urandom_range(0, 3));
    if (r < 40) begin
      op = OP_TICK;
    end else if (r < 60) begin
      op = OP_SAMPLE;
    end else if (r < 88) begin
      op = OP_PRESSED;
      if ($urandom_range(0, 99) < 70) mode = MODE_REPEAT;
    end else begin
      op = OP_RELEASE;
    end
    if (op != OP_PRESSED && op != OP_RELEASE && $urandom_range(0, 1) == 0)
      key = 8'($urandom_range(0, 255));
    send_item(op, key, ($urandom_range(0, 99) < 65), mode, 1'b0, 1'b0);
  endtask

  // Receiver: random stalls plus requested long hold-offs.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Answer checker
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("answer transaction with nothing pending: answer=%b", answer);
      end else begin
        if (answer !== pending_answers[0]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("answer mismatch: expected %b, got %b", pending_answers[0], answer);
        end
        void'(pending_answers.pop_front());
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
        (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [7:0] pool [4];
    reset_key_table();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].lvl,
                directed_rows[i].mode, directed_rows[i].fixed, directed_rows[i].ans);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0; end
        1: begin
          write_reg(REG_FIRST_DELAY, 16'd0);
          write_reg(REG_REPEAT, 16'd0);
          send_idle_pct = 0;  recv_stall_pct = 0;
        end
        2: begin
          write_reg(REG_FIRST_DELAY, 16'd8);
          write_reg(REG_REPEAT, 16'd3);
          write_reg(REG_SPARE_A, 16'($urandom_range(0, 65535)));
          send_idle_pct = 72; recv_stall_pct = 0;
        end
        3: begin
          write_reg(REG_FIRST_DELAY, 16'hffff);
          write_reg(REG_REPEAT, 16'hffff);
          send_idle_pct = 0;  recv_stall_pct = 72;
        end
        4: begin
          write_reg(REG_FIRST_DELAY, 16'd20);
          write_reg(REG_REPEAT, 16'd5);
          write_reg(REG_SPARE_B, 16'($urandom_range(0, 65535)));
          send_idle_pct = 17; recv_stall_pct = 17;
        end
        5: begin
          write_reg(REG_FIRST_DELAY, 16'd0);
          write_reg(REG_REPEAT, 16'hffff);
          send_idle_pct = 0;  recv_stall_pct = 0;
        end
        6: begin
          write_reg(REG_FIRST_DELAY, 16'd12);
          write_reg(REG_REPEAT, 16'd0);
          send_idle_pct = 0;  recv_stall_pct = 72;
        end
        7: begin
          write_reg(REG_FIRST_DELAY, 16'($urandom_range(0, 30)));
          write_reg(REG_REPEAT, 16'($urandom_range(0, 10)));
          send_idle_pct = 17; recv_stall_pct = 17;
        end
        default: begin
          write_reg(REG_FIRST_DELAY, 16'($urandom_range(0, 65535)));
          write_reg(REG_REPEAT, 16'($urandom_range(0, 65535)));
          send_idle_pct = 72; recv_stall_pct = 72;
        end
      endcase
      foreach (pool[k]) pool[k] = 8'($urandom_range(0, 255));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long receiver hold-off while items keep coming
        if (n == 60 && (p == 0 || p == 5)) hold_requests++;
        // sender waits for every answer before going on
        if (n == ITEMS_PER_PHASE / 2 && p == 2) drain_answers();
        send_random_item(pool);
      end
    end

    drain_answers();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
